FILE: rtl/stream_pattern_replace_core_assert.svh
// Assertion macros used by the checker file.
`ifndef STREAM_PATTERN_REPLACE_CORE_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/spr_pkg.sv
`default_nettype none

package spr_pkg;

	localparam int MAX_LEN_DEF     = 8;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
	localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
	localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
	localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic [63:0] replacement_bytes;
		logic [3:0]  replacement_length;
	} spr_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/spr_front.sv
`default_nettype none

module spr_front import spr_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  spr_cfg_t                                   cfg,
	input  logic                                       text_valid,
	output logic                                       text_stall,
	input  logic [7:0]                                 text_byte,
	input  logic                                       end_of_text,
	input  logic                                       q_full,
	output logic                                       push,
	output logic [8*MAX_LEN+$clog2(MAX_LEN+1):0]       cmd
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int SW = CW + 1;
	localparam int AW = $clog2(MAX_LEN);

	logic [7:0]             win_q [MAX_LEN];
	logic [CW-1:0]          cnt_q;

	logic [7:0]             w [MAX_LEN];
	logic [7:0]             win_d [MAX_LEN];
	logic [8*MAX_LEN-1:0]   packed_w;
	logic [CW-1:0]          c;
	logic [CW-1:0]          plen;
	logic [CW-1:0]          rlen;
	logic [CW-1:0]          k;
	logic [CW-1:0]          n;
	logic [SW-1:0]          src;
	logic                   match;
	logic                   take;
	logic                   accept;

	assign text_stall = q_full;
	assign accept     = text_valid && !q_full;

	always_comb begin
		if (cfg.pattern_length == 4'd0) begin
			plen = CW'(1);
		end else if (cfg.pattern_length > 4'(MAX_LEN)) begin
			plen = CW'(MAX_LEN);
		end else begin
			plen = CW'(cfg.pattern_length);
		end
		if (cfg.replacement_length > 4'(MAX_LEN)) begin
			rlen = CW'(MAX_LEN);
		end else begin
			rlen = CW'(cfg.replacement_length);
		end

		c = cnt_q + CW'(1);

		// append the new byte behind the pending ones
		for (int i = 0; i < MAX_LEN; i++) begin
			w[i] = (CW'(i) == cnt_q) ? text_byte : win_q[i];
			packed_w[8*i +: 8] = w[i];
		end

		match = 1'b1;
		for (int i = 0; i < MAX_LEN; i++) begin
			if (CW'(i) < plen && w[i] != cfg.pattern_bytes[8*i +: 8]) begin
				match = 1'b0;
			end
		end
		take = (c == plen) && match;

		// number of oldest bytes that leave the window unchanged
		if (c > plen) begin
			k = c - plen + CW'(1);
		end else if (c == plen && !match) begin
			k = CW'(1);
		end else begin
			k = '0;
		end

		if (take) begin
			n = rlen;
		end else if (end_of_text) begin
			n = c;
		end else begin
			n = k;
		end

		for (int i = 0; i < MAX_LEN; i++) begin
			src = SW'(i) + {1'b0, k};
			win_d[i] = (src < SW'(MAX_LEN)) ? w[src[AW-1:0]] : w[i];
		end

		push = accept && (n != '0 || end_of_text);
		cmd  = {end_of_text, n,
			take ? cfg.replacement_bytes[8*MAX_LEN-1:0] : packed_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= (take || end_of_text) ? '0 : c - k;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_LEN; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/spr_queue.sv
`default_nettype none

module spr_queue import spr_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] head,
	input  logic             pop
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full       = (count_q == NW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/spr_back.sv
`default_nettype none

module spr_back import spr_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  logic [8*MAX_LEN+$clog2(MAX_LEN+1):0] head,
	output logic                                 pop,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [7:0]                           out_byte,
	output logic                                 byte_present,
	output logic                                 last
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam int BW = 8 * MAX_LEN;

	logic [BW-1:0] cur_bytes_q;
	logic [CW-1:0] cur_n_q;
	logic          cur_eot_q;
	logic          cur_valid_q;
	logic [AW-1:0] idx_q;

	logic          at_fin;
	logic          done;
	logic          advance;

	// final result of the current request; an empty request is the end marker
	assign at_fin  = (cur_n_q == '0) || (CW'(idx_q) + CW'(1) == cur_n_q);
	assign done    = cur_valid_q && !result_stall && at_fin;
	assign advance = cur_valid_q && !result_stall && !at_fin;
	assign pop     = head_valid && (!cur_valid_q || done);

	assign result_valid = cur_valid_q;
	assign byte_present = (cur_n_q != '0);
	assign out_byte     = byte_present ? cur_bytes_q[8*idx_q +: 8] : 8'd0;
	assign last         = cur_eot_q && at_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (done) begin
			cur_valid_q <= 1'b0;
		end else if (advance) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_bytes_q <= head[BW-1:0];
			cur_n_q     <= head[BW +: CW];
			cur_eot_q   <= head[BW+CW];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/stream_pattern_replace_core.sv
// Streaming find-and-replace, one text byte per request.
// Accepted requests pass through the queue into the output stage. One request is
// taken per cycle while each gives at most one result and the output is not stalled;
// a request with more results holds the output; a 4-entry queue absorbs bursts.
// Reset (arst_n low) empties the window, queue and output stage and restores registers.
`default_nettype none

module stream_pattern_replace_core import spr_pkg::*; #(
	parameter int MAX_LEN     = MAX_LEN_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_byte,
	output logic        byte_present,
	output logic        last
);

	localparam int EW = 8 * MAX_LEN + $clog2(MAX_LEN + 1) + 1;

	spr_cfg_t      cfg_q;
	logic          push;
	logic [EW-1:0] cmd;
	logic          q_full;
	logic          head_valid;
	logic [EW-1:0] head;
	logic          pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes      <= '0;
			cfg_q.pattern_length     <= 4'd1;
			cfg_q.replacement_bytes  <= '0;
			cfg_q.replacement_length <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PATTERN_BYTES: begin
					cfg_q.pattern_bytes <= wr_data;
				end
				REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= wr_data[3:0];
				end
				REG_REPLACEMENT_BYTES: begin
					cfg_q.replacement_bytes <= wr_data;
				end
				REG_REPLACEMENT_LENGTH: begin
					cfg_q.replacement_length <= wr_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	spr_front #(
		.MAX_LEN(MAX_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.q_full     (q_full),
		.push       (push),
		.cmd        (cmd)
	);

	spr_queue #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (cmd),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	spr_back #(
		.MAX_LEN(MAX_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte    (out_byte),
		.byte_present(byte_present),
		.last        (last)
	);

endmodule

`default_nettype wire

FILE: rtl/spr_checker.sv
`default_nettype none
`include "stream_pattern_replace_core_assert.svh"

module spr_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       result_valid,
	input wire       result_stall,
	input wire [7:0] out_byte,
	input wire       byte_present,
	input wire       last
);

	`SPR_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(out_byte) && $stable(byte_present) && $stable(last), "stalled result changed")

	// an empty result only ever closes a text
	`SPR_ASSERT_SAME(a_marker_last, result_valid && !byte_present, last, "empty result without last")

	`SPR_ASSERT_SAME(a_marker_zero, result_valid && !byte_present, out_byte == 8'd0, "empty result carries a byte")

endmodule

bind stream_pattern_replace_core spr_checker u_checker (.*);

`default_nettype wire
